/* sv/lcfb_pkg.sv */
package lcfb_pkg;

  localparam int POS_IN_W    = 3;
  localparam int RAW_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN   = 23;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

  typedef logic [IDX_W-1:0]    pos_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [POS_IN_W-1:0] louver_idx_t;
  typedef logic [RAW_W-1:0]    raw_t;

  // frame byte positions
  localparam pos_t POS_CRC_FIRST = 5'd10;
  localparam pos_t POS_VRAW      = 5'd15;
  localparam pos_t POS_HRAW      = 5'd19;
  localparam pos_t POS_ID        = 5'd20;
  localparam pos_t POS_CRC       = 5'd21;
  localparam pos_t POS_SUM       = 5'd22;

  // fixed part of the frame; variable positions hold zero
  localparam byte_t FRAME_TPL [FRAME_LEN] = '{
    8'hAA, 8'h16, 8'hAC, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h02, 8'h02, 8'hB0, 8'h02, 8'h09, 8'h00, 8'h01, 8'h00,
    8'h0A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic  rejected;
    raw_t  vraw;
    raw_t  hraw;
    byte_t msg_id;
  } cmd_t;

endpackage

/* sv/lcfb_in_if.sv */
interface lcfb_in_if;
  import lcfb_pkg::*;

  logic        valid;
  logic        ready;
  louver_idx_t vertical_position;
  louver_idx_t horizontal_position;

  modport source (output valid, vertical_position, horizontal_position, input ready);
  modport sink   (input valid, vertical_position, horizontal_position, output ready);
endinterface

/* sv/lcfb_out_if.sv */
interface lcfb_out_if;
  import lcfb_pkg::*;

  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  last;
  logic  rejected;

  modport source (output valid, frame_byte, last, rejected, input ready);
  modport sink   (input valid, frame_byte, last, rejected, output ready);
endinterface

/* sv/louver_command_frame_builder.sv */
// Louver command frame builder. Each input transaction carries a vertical and
// a horizontal louver index (1..5). A valid pair produces 23 output
// transactions, one frame byte each, ending in a reflected CRC-8 over bytes
// 10..20 and a negated checksum over bytes 1..21, with last set on the final
// byte; the 8-bit message id then advances. An index outside 1..5 produces a
// single output transaction with frame_byte 0, last and rejected set, and
// leaves the id alone. Frames leave at one byte per cycle while the receiver
// keeps ready high, a rate set by the byte-serial output stage. The front end
// classifies and stamps requests into a QDEPTH-entry command queue, so up to
// QDEPTH requests are taken while a frame is still going out. A first byte
// passes through the queue entry, cur_r and the output register obyte_r.
module louver_command_frame_builder #(
  parameter int QDEPTH = lcfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lcfb_in_if.sink     in_if,
  lcfb_out_if.source  out_if
);
  import lcfb_pkg::*;

  logic q_push, q_ready, q_pop, q_valid;
  cmd_t q_wdata, q_rdata;

  lcfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_ready(q_ready)
  );

  lcfb_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .pop_valid (q_valid)
  );

  lcfb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

`ifndef NO_ASSERTIONS
  a_rej_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.rejected |-> out_if.last && (out_if.frame_byte == '0))
    else $error("rejection not a single zero byte");

  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_wdata.rejected |-> (q_wdata.vraw != '0) && (q_wdata.hraw != '0)
      && (in_if.vertical_position != '0) && (in_if.horizontal_position != '0))
    else $error("invalid index queued as a frame");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_wdata.rejected ##1 q_push && !q_wdata.rejected
      |-> q_wdata.msg_id == $past(q_wdata.msg_id) + 8'd1)
    else $error("message id did not advance");
`endif

endmodule

/* sv/lcfb_front.sv */
module lcfb_front (
  input  logic          clk,
  input  logic          rst_n,
  lcfb_in_if.sink       in_if,
  output logic          q_push,
  output lcfb_pkg::cmd_t q_data,
  input  logic          q_ready
);
  import lcfb_pkg::*;

  byte_t msg_cnt_r, msg_cnt_nxt;
  raw_t  vraw, hraw;

  function automatic raw_t idx_to_raw(input louver_idx_t idx);
    raw_t r;
    case (idx)
      3'd1:    r = 7'd1;
      3'd2:    r = 7'd25;
      3'd3:    r = 7'd50;
      3'd4:    r = 7'd75;
      3'd5:    r = 7'd100;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign vraw        = idx_to_raw(in_if.vertical_position);
  assign hraw        = idx_to_raw(in_if.horizontal_position);
  assign in_if.ready = q_ready;
  assign q_push      = in_if.valid && q_ready;

  always_comb begin
    q_data.rejected = (vraw == '0) || (hraw == '0);
    q_data.vraw     = vraw;
    q_data.hraw     = hraw;
    q_data.msg_id   = msg_cnt_r;
    msg_cnt_nxt     = msg_cnt_r;
    if (q_push && !q_data.rejected) begin
      msg_cnt_nxt = msg_cnt_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_cnt_r <= '0;
    end else begin
      msg_cnt_r <= msg_cnt_nxt;
    end
  end

endmodule

/* sv/lcfb_queue.sv */
module lcfb_queue #(
  parameter int DEPTH = lcfb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcfb_pkg::cmd_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output lcfb_pkg::cmd_t pop_data,
  output logic           pop_valid
);
  import lcfb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lcfb_back.sv */
module lcfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lcfb_pkg::cmd_t q_data,
  output logic           q_pop,
  lcfb_out_if.source     out_if
);
  import lcfb_pkg::*;

  cmd_t  cur_r, cur_nxt;
  logic  busy_r, busy_nxt;
  pos_t  idx_r, idx_nxt;
  byte_t crc_r, crc_nxt;
  byte_t sum_r, sum_nxt;
  logic  ov_r, ov_nxt;
  byte_t obyte_r, obyte_nxt;
  logic  olast_r, olast_nxt;
  logic  orej_r, orej_nxt;

  logic  emit, is_last;
  byte_t cur_byte;

  function automatic byte_t crc8_step(input byte_t crc_in, input byte_t v);
    byte_t c;
    logic  mix;
    c = crc_in;
    for (int b = 0; b < BYTE_W; b++) begin
      mix = c[0] ^ v[b];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  assign emit    = busy_r && (!ov_r || out_if.ready);
  assign is_last = cur_r.rejected || (idx_r == POS_SUM);
  assign q_pop   = q_valid && (!busy_r || (emit && is_last));

  always_comb begin
    cur_byte = FRAME_TPL[idx_r];
    if (cur_r.rejected) begin
      cur_byte = '0;
    end else if (idx_r == POS_VRAW) begin
      cur_byte = {1'b0, cur_r.vraw};
    end else if (idx_r == POS_HRAW) begin
      cur_byte = {1'b0, cur_r.hraw};
    end else if (idx_r == POS_ID) begin
      cur_byte = cur_r.msg_id;
    end else if (idx_r == POS_CRC) begin
      cur_byte = crc_r;
    end else if (idx_r == POS_SUM) begin
      cur_byte = 8'd0 - sum_r;
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    orej_nxt  = orej_r;

    if (emit) begin
      ov_nxt    = 1'b1;
      obyte_nxt = cur_byte;
      olast_nxt = is_last;
      orej_nxt  = cur_r.rejected;
    end else if (out_if.ready) begin
      ov_nxt = 1'b0;
    end

    if (q_pop) begin
      cur_nxt  = q_data;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      crc_nxt  = '0;
      sum_nxt  = '0;
    end else if (emit && is_last) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r inside {[5'd1:POS_CRC]}) begin
        sum_nxt = sum_r + cur_byte;
      end
      if (idx_r inside {[POS_CRC_FIRST:POS_ID]}) begin
        crc_nxt = crc8_step(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    crc_r   <= crc_nxt;
    sum_r   <= sum_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    orej_r  <= orej_nxt;
  end

  assign out_if.valid      = ov_r;
  assign out_if.frame_byte = obyte_r;
  assign out_if.last       = olast_r;
  assign out_if.rejected   = orej_r;

endmodule

/* sim/louver_frame_checker.sv */
module louver_frame_checker
  import lcfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lcfb_in_if   in_if,
  lcfb_out_if  out_if,
  output int   fail_count,
  output int   outstanding
);

  localparam byte_t CRC8_POLY    = 8'h8C;
  localparam int    REPORT_LIMIT = 10;

  typedef struct packed {
    byte_t frame_byte;
    logic  last;
    logic  rejected;
  } frame_beat_t;

  frame_beat_t expected_beats[$];
  byte_t       next_msg_id = '0;
  int          mismatches  = 0;

  assign fail_count = mismatches;

  function automatic byte_t louver_raw(louver_idx_t idx);
    case (idx)
      3'd1:    return 8'd1;
      3'd2:    return 8'd25;
      3'd3:    return 8'd50;
      3'd4:    return 8'd75;
      3'd5:    return 8'd100;
      default: return 8'd0;
    endcase
  endfunction

  // reflected CRC-8, zero init, no final xor
  function automatic byte_t crc8_lsb_first(byte_t data [FRAME_LEN], int first, int count);
    byte_t crc;
    byte_t v;
    crc = '0;
    for (int i = first; i < first + count; i++) begin
      v = data[i];
      for (int b = 0; b < 8; b++) begin
        if ((crc[0] ^ v[0]) == 1'b1) begin
          crc = (crc >> 1) ^ CRC8_POLY;
        end else begin
          crc = crc >> 1;
        end
        v = v >> 1;
      end
    end
    return crc;
  endfunction

  task automatic queue_command_frame(input louver_idx_t v_idx, input louver_idx_t h_idx);
    byte_t       fr [FRAME_LEN];
    byte_t       vraw;
    byte_t       hraw;
    byte_t       sum;
    frame_beat_t beat;
    vraw = louver_raw(v_idx);
    hraw = louver_raw(h_idx);
    if (vraw == 8'd0 || hraw == 8'd0) begin
      beat.frame_byte = '0;
      beat.last       = 1'b1;
      beat.rejected   = 1'b1;
      expected_beats.push_back(beat);
      return;
    end
    fr = '{8'hAA, 8'h16, 8'hAC, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00,
           8'h02, 8'h02, 8'hB0, 8'h02, 8'h09, 8'h00, 8'h01, 8'h00,
           8'h0A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    fr[15] = vraw;
    fr[19] = hraw;
    fr[20] = next_msg_id;
    next_msg_id = next_msg_id + 8'd1;
    fr[21] = crc8_lsb_first(fr, 10, 11);
    sum = '0;
    for (int i = 1; i < 22; i++) begin
      sum = sum + fr[i];
    end
    fr[22] = 8'd0 - sum;
    for (int i = 0; i < FRAME_LEN; i++) begin
      beat.frame_byte = fr[i];
      beat.last       = (i == FRAME_LEN - 1);
      beat.rejected   = 1'b0;
      expected_beats.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      next_msg_id = '0;
      expected_beats.delete();
    end else begin
      if (in_if.valid && in_if.ready) begin
        queue_command_frame(in_if.vertical_position, in_if.horizontal_position);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected transaction: byte %02h last %0b rejected %0b",
                     out_if.frame_byte, out_if.last, out_if.rejected);
          end
        end else begin
          want = expected_beats.pop_front();
          if (out_if.frame_byte !== want.frame_byte || out_if.last !== want.last ||
              out_if.rejected !== want.rejected) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch: expected byte %02h last %0b rejected %0b, got %02h %0b %0b",
                       want.frame_byte, want.last, want.rejected,
                       out_if.frame_byte, out_if.last, out_if.rejected);
            end
          end
        end
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

/* sim/louver_command_frame_builder_test.sv */
module louver_command_frame_builder_test;
  import lcfb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 46;
  localparam int DRAIN_CYCLES = 30;
  localparam int N_DIRECTED   = 14;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_left     = 0;
  logic hold_trigger  = 1'b0;
  logic hold_seen     = 1'b0;
  int   fail_count;
  int   outstanding;

  // send idle / receiver stall per phase
  int idle_tab  [4] = '{0, 68, 0, 30};
  int stall_tab [4] = '{0, 0, 68, 30};

  louver_idx_t dir_v [N_DIRECTED] = '{3'd1, 3'd5, 3'd1, 3'd5, 3'd2, 3'd3, 3'd4,
                                      3'd0, 3'd3, 3'd6, 3'd2, 3'd7, 3'd0, 3'd7};
  louver_idx_t dir_h [N_DIRECTED] = '{3'd1, 3'd5, 3'd5, 3'd1, 3'd3, 3'd4, 3'd2,
                                      3'd3, 3'd0, 3'd2, 3'd6, 3'd7, 3'd0, 3'd5};

  lcfb_in_if  in_if ();
  lcfb_out_if out_if ();

  louver_command_frame_builder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  louver_frame_checker frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen    <= hold_trigger;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic offer_request(input louver_idx_t v_idx, input louver_idx_t h_idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid               <= 1'b1;
    in_if.vertical_position   <= v_idx;
    in_if.horizontal_position <= h_idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic louver_idx_t bad_index();
    case ($urandom_range(0, 2))
      0:       return 3'd0;
      1:       return 3'd6;
      default: return 3'd7;
    endcase
  endfunction

  task automatic offer_random_request();
    louver_idx_t v_idx;
    louver_idx_t h_idx;
    v_idx = louver_idx_t'($urandom_range(1, 5));
    h_idx = louver_idx_t'($urandom_range(1, 5));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       v_idx = bad_index();
        1:       h_idx = bad_index();
        default: begin
          v_idx = bad_index();
          h_idx = bad_index();
        end
      endcase
    end
    offer_request(v_idx, h_idx);
  endtask

  initial begin
    in_if.valid               <= 1'b0;
    in_if.vertical_position   <= '0;
    in_if.horizontal_position <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_request(dir_v[i], dir_h[i]);
    end

    // long receiver hold-off while requests keep coming
    hold_trigger <= ~hold_trigger;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct <= idle_tab[p];
      stall_pct     <= stall_tab[p];
      repeat (PHASE_ITEMS) offer_random_request();
    end
    in_if.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("louver_command_frame_builder_test OK");
    end else begin
      $display("louver_command_frame_builder_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("louver_command_frame_builder_test NOT OK");
    $finish;
  end

endmodule

/* louver_command_frame_builder.f */
sv/lcfb_pkg.sv
sv/lcfb_in_if.sv
sv/lcfb_out_if.sv
sv/lcfb_front.sv
sv/lcfb_queue.sv
sv/lcfb_back.sv
sv/louver_command_frame_builder.sv
sim/louver_frame_checker.sv
sim/louver_command_frame_builder_test.sv
